@@ design/hnaf_pkg.sv @@
// shared codes, constants and types for the hdlc nrzi tone framer
`timescale 1ns / 1ps

package hnaf_pkg;

    typedef enum logic [1:0] {
        CMD_DATA      = 2'd0,
        CMD_FLAG      = 2'd1,
        CMD_CRC_RESET = 2'd2,
        CMD_FCS       = 2'd3
    } command_t;

    localparam int unsigned CRC_W = 16;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8408;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hffff;

    localparam logic [2:0] STUFF_LIMIT = 3'd5;
    localparam logic [2:0] ONES_MAX    = 3'd7;

    // control from the bit sequencer to the frame check unit
    typedef struct packed {
        logic init;
        logic shift;
        logic din;
    } crc_ctrl_t;

endpackage

@@ design/hnaf_if.sv @@
// request and result channel interfaces of the framer
`timescale 1ns / 1ps

interface hnaf_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface hnaf_tone_if;
    logic valid;
    logic ready;
    logic tone;
    logic stuffed;
    logic last;

    modport source (output valid, output tone, output stuffed, output last, input ready);
    modport sink (input valid, input tone, input stuffed, input last, output ready);
endinterface

@@ design/hnaf_crc.sv @@
// bit-serial crc-16 frame check register, reflected polynomial
`timescale 1ns / 1ps

module hnaf_crc (
    input  logic                               clk,
    input  logic                               rst_n,
    input  hnaf_pkg::crc_ctrl_t                ctrl,
    output logic [hnaf_pkg::CRC_W-1:0]         crc
);
    import hnaf_pkg::*;

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic             feedback;

    always_comb
    begin
        feedback = crc_reg[0] ^ ctrl.din;
        crc_next = crc_reg;
        if (ctrl.init)
        begin
            crc_next = CRC_INIT;
        end
        else if (ctrl.shift)
        begin
            crc_next = {1'b0, crc_reg[CRC_W-1:1]} ^ (feedback ? CRC_POLY : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

@@ design/hnaf_bitseq.sv @@
// bit sequencer: shifts bytes out lsb first with nrzi coding, and bit stuffing on all but flag bytes
`timescale 1ns / 1ps

module hnaf_bitseq (
    input  logic                               clk,
    input  logic                               rst_n,
    hnaf_cmd_if.sink                           cmd,
    hnaf_tone_if.source                        res,
    input  logic [hnaf_pkg::CRC_W-1:0]         crc,
    output hnaf_pkg::crc_ctrl_t                crc_ctrl
);
    import hnaf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEND,
        ST_STUFF
    } state_t;

    state_t           state_reg, state_next;
    logic [CRC_W-1:0] shift_reg, shift_next;
    logic [4:0]       left_reg, left_next;
    logic             stuff_en_reg, stuff_en_next;
    logic             tone_state_reg, tone_state_next;
    logic [2:0]       ones_reg, ones_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_tone_reg, out_tone_next;
    logic             out_stuffed_reg, out_stuffed_next;
    logic             out_last_reg, out_last_next;

    logic       accept;
    logic       slot_free;
    logic       bit_cur;
    logic [2:0] ones_inc;
    logic       will_stuff;
    command_t   op;

    assign op        = command_t'(cmd.command);
    assign accept    = cmd.valid && cmd.ready;
    assign slot_free = !out_valid_reg || res.ready;
    assign bit_cur   = shift_reg[0];
    assign ones_inc  = (ones_reg == ONES_MAX) ? ones_reg : ones_reg + 3'd1;
    assign will_stuff = stuff_en_reg && bit_cur && (ones_inc == STUFF_LIMIT);

    always_comb
    begin
        state_next       = state_reg;
        shift_next       = shift_reg;
        left_next        = left_reg;
        stuff_en_next    = stuff_en_reg;
        tone_state_next  = tone_state_reg;
        ones_next        = ones_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        out_tone_next    = out_tone_reg;
        out_stuffed_next = out_stuffed_reg;
        out_last_next    = out_last_reg;
        crc_ctrl         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        CMD_DATA, CMD_FLAG:
                        begin
                            shift_next    = {8'h00, cmd.data_byte};
                            left_next     = 5'd8;
                            stuff_en_next = (op == CMD_DATA);
                            state_next    = ST_SEND;
                        end
                        CMD_FCS:
                        begin
                            // both complemented bytes are captured before any go out
                            shift_next    = ~crc;
                            left_next     = 5'd16;
                            stuff_en_next = 1'b1;
                            state_next    = ST_SEND;
                        end
                        default:
                        begin
                            crc_ctrl.init = 1'b1;
                        end
                    endcase
                end
            end
            ST_SEND:
            begin
                if (slot_free)
                begin
                    crc_ctrl.shift = 1'b1;
                    crc_ctrl.din   = bit_cur;
                    if (bit_cur)
                    begin
                        ones_next = ones_inc;
                    end
                    else
                    begin
                        tone_state_next = !tone_state_reg;
                        ones_next       = 3'd0;
                    end
                    out_valid_next   = 1'b1;
                    out_tone_next    = bit_cur ? tone_state_reg : !tone_state_reg;
                    out_stuffed_next = 1'b0;
                    out_last_next    = (left_reg == 5'd1) && !will_stuff;
                    shift_next       = {1'b0, shift_reg[CRC_W-1:1]};
                    left_next        = left_reg - 5'd1;
                    if (will_stuff)
                    begin
                        state_next = ST_STUFF;
                    end
                    else if (left_reg == 5'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_STUFF:
            begin
                if (slot_free)
                begin
                    tone_state_next  = !tone_state_reg;
                    ones_next        = 3'd0;
                    out_valid_next   = 1'b1;
                    out_tone_next    = !tone_state_reg;
                    out_stuffed_next = 1'b1;
                    out_last_next    = (left_reg == 5'd0);
                    state_next       = (left_reg == 5'd0) ? ST_IDLE : ST_SEND;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            shift_reg       <= '0;
            left_reg        <= '0;
            stuff_en_reg    <= 1'b0;
            tone_state_reg  <= 1'b0;
            ones_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_tone_reg    <= 1'b0;
            out_stuffed_reg <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            shift_reg       <= shift_next;
            left_reg        <= left_next;
            stuff_en_reg    <= stuff_en_next;
            tone_state_reg  <= tone_state_next;
            ones_reg        <= ones_next;
            out_valid_reg   <= out_valid_next;
            out_tone_reg    <= out_tone_next;
            out_stuffed_reg <= out_stuffed_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign cmd.ready   = (state_reg == ST_IDLE);
    assign res.valid   = out_valid_reg;
    assign res.tone    = out_tone_reg;
    assign res.stuffed = out_stuffed_reg;
    assign res.last    = out_last_reg;

endmodule

@@ design/hdlc_nrzi_afsk_framer.sv @@
// top level of the hdlc framer with nrzi tone coding and crc-16 frame check
// the taken request moves the sequencer into its send state, from which the first bit period is registered
// throughput: one bit period per cycle while the result channel has room for it
// the shift register holds the byte or both fcs bytes being sent; a crc reset sends none
// a new request is taken once the last bit period of the previous one is registered
// reset: tone 0, ones count 0, frame check 0xffff, no result pending
`timescale 1ns / 1ps

module hdlc_nrzi_afsk_framer (
    input  logic         clk,
    input  logic         rst_n,
    hnaf_cmd_if.sink     cmd,
    hnaf_tone_if.source  res
);
    import hnaf_pkg::*;

    crc_ctrl_t        crc_ctrl;
    logic [CRC_W-1:0] crc;

    hnaf_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .crc   (crc)
    );

    hnaf_bitseq u_bitseq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .res      (res),
        .crc      (crc),
        .crc_ctrl (crc_ctrl)
    );

endmodule
